// ===== rtl/qjmc_pkg.sv =====
// shared widths, constants and types of the quintic coefficient pipeline
package qjmc_pkg;

   localparam int unsigned VAL_W = 32;
   localparam int unsigned DUR_W = 24;

   // boundary residual terms and numerators
   localparam int unsigned XW = 84;
   localparam int unsigned NUMW = 88;
   localparam int unsigned MAGW = 87;

   // quotient bits per divider: 32 result bits plus one rounding bit
   localparam int unsigned QW = 33;

   // denominators d^3, d^4, d^5
   localparam int unsigned DEN3_W = 72;
   localparam int unsigned DEN4_W = 96;
   localparam int unsigned DEN5_W = 120;

   // numerator alignment shifts into Q16.16
   localparam int unsigned SH3 = 14;
   localparam int unsigned SH4 = 31;
   localparam int unsigned SH5 = 46;

   localparam int unsigned FRONT_LAT = 11;
   localparam int unsigned DIV_LAT = QW + 2;
   localparam int unsigned PIPE_LAT = FRONT_LAT + DIV_LAT;

   localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [MAGW-1:0] mag;
      logic            neg;
      logic            dzero;
   } div_in_type;

   typedef struct packed {
      logic [VAL_W-1:0] coef;
      logic             sat;
   } div_out_type;

   typedef struct packed {
      logic [VAL_W-1:0] coef0;
      logic [VAL_W-1:0] coef1;
      logic [VAL_W-1:0] coef2;
      logic             dzero;
   } side_type;

   typedef struct packed {
      logic [VAL_W-1:0] coef0;
      logic [VAL_W-1:0] coef1;
      logic [VAL_W-1:0] coef2;
      logic [VAL_W-1:0] coef3;
      logic [VAL_W-1:0] coef4;
      logic [VAL_W-1:0] coef5;
      logic             error_flag;
   } rsp_type;

endpackage

// ===== rtl/qjmc_req_if.sv =====
// request channel: start state, end state and duration
interface qjmc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qjmc_pkg::VAL_W-1:0]    start_pos;
   logic signed [qjmc_pkg::VAL_W-1:0]    start_vel;
   logic signed [qjmc_pkg::VAL_W-1:0]    start_acc;
   logic signed [qjmc_pkg::VAL_W-1:0]    end_pos;
   logic signed [qjmc_pkg::VAL_W-1:0]    end_vel;
   logic signed [qjmc_pkg::VAL_W-1:0]    end_acc;
   logic        [qjmc_pkg::DUR_W-1:0]    duration;

   modport source (output valid, start_pos, start_vel, start_acc, end_pos, end_vel,
                   end_acc, duration, input ready);
   modport sink (input valid, start_pos, start_vel, start_acc, end_pos, end_vel,
                 end_acc, duration, output ready);
endinterface

// ===== rtl/qjmc_rsp_if.sv =====
// response channel: six quintic coefficients and error flag
interface qjmc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qjmc_pkg::VAL_W-1:0]    coef0;
   logic signed [qjmc_pkg::VAL_W-1:0]    coef1;
   logic signed [qjmc_pkg::VAL_W-1:0]    coef2;
   logic signed [qjmc_pkg::VAL_W-1:0]    coef3;
   logic signed [qjmc_pkg::VAL_W-1:0]    coef4;
   logic signed [qjmc_pkg::VAL_W-1:0]    coef5;
   logic                                 error_flag;

   modport source (output valid, coef0, coef1, coef2, coef3, coef4, coef5, error_flag,
                   input ready);
   modport sink (input valid, coef0, coef1, coef2, coef3, coef4, coef5, error_flag,
                 output ready);
endinterface

// ===== rtl/qjmc_mul.sv =====
// two-stage signed by duration multiplier built from 25x25 partial products
module qjmc_mul #(
   parameter int unsigned AW = 32
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [AW-1:0]                   a,
   input  logic        [qjmc_pkg::DUR_W-1:0]      d,
   output logic signed [AW+qjmc_pkg::DUR_W-1:0]   p
);

   localparam int unsigned CH = qjmc_pkg::DUR_W;
   localparam int unsigned PW = AW + CH;
   localparam int unsigned NC = (AW + CH - 1) / CH;
   localparam int unsigned EW = NC * CH;
   localparam int unsigned PPW = 2 * (CH + 1);

   logic signed [EW-1:0]  a_ext;
   logic signed [PPW-1:0] pp_in [NC];
   logic signed [PPW-1:0] pp_ff [NC];
   logic signed [PW-1:0]  acc;
   logic signed [PW-1:0]  p_ff;

   assign a_ext = EW'(a);

   // low chunks are unsigned, the top chunk carries the sign
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         if (i == NC - 1) begin
            pp_in[i] = $signed({a_ext[i*CH+CH-1], a_ext[i*CH +: CH]}) * $signed({1'b0, d});
         end else begin
            pp_in[i] = $signed({1'b0, a_ext[i*CH +: CH]}) * $signed({1'b0, d});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff <= pp_in;
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NC; i++) begin
         acc = acc + (PW'(pp_ff[i]) <<< (CH * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= acc;
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/qjmc_div.sv =====
// pipelined restoring divider: one quotient bit per stage, round and saturate
module qjmc_div #(
   parameter int unsigned DW = 72,
   parameter int unsigned SH = 14
) (
   input  logic                        clock,
   input  logic                        en,
   input  qjmc_pkg::div_in_type        din,
   input  logic [DW-1:0]               den,
   output qjmc_pkg::div_out_type       dout
);

   localparam int unsigned QW = qjmc_pkg::QW;
   localparam int unsigned NW = qjmc_pkg::MAGW + 1 + SH;
   localparam int unsigned RW = DW + 1;
   localparam int unsigned CW = (NW > DW + QW + 1) ? NW : DW + QW + 1;

   typedef struct packed {
      logic neg;
      logic dzero;
      logic ovf;
      logic nz;
   } dctl_type;

   logic [NW-1:0]  num;
   logic [CW-1:0]  num_w;
   logic [CW-1:0]  lim_w;
   dctl_type       ctl_in;

   logic [RW-1:0]  r_ff   [QW+1];
   logic [QW-1:0]  low_ff [QW+1];
   logic [QW-1:0]  q_ff   [QW+1];
   logic [DW-1:0]  den_ff [QW+1];
   dctl_type       ctl_ff [QW+1];

   logic [QW-1:0]  rnd;
   logic [QW-1:0]  limit;
   logic           over;
   qjmc_pkg::div_out_type res_in;
   qjmc_pkg::div_out_type res_ff;

   // twice the shifted magnitude, so the last quotient bit is the rounding bit
   assign num = {din.mag, {(SH + 1){1'b0}}};
   assign num_w = CW'(num);
   assign lim_w = CW'(den) << QW;

   always_comb begin
      ctl_in.neg = din.neg;
      ctl_in.dzero = din.dzero;
      ctl_in.ovf = (num_w >= lim_w);
      ctl_in.nz = |din.mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= RW'(num_w >> QW);
         low_ff[0] <= num[QW-1:0];
         q_ff[0] <= '0;
         den_ff[0] <= den;
         ctl_ff[0] <= ctl_in;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [RW-1:0] t;
      logic          ge;

      assign t = {r_ff[k-1][RW-2:0], low_ff[k-1][QW-1]};
      assign ge = (t >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= ge ? (t - {1'b0, den_ff[k-1]}) : t;
            low_ff[k] <= {low_ff[k-1][QW-2:0], 1'b0};
            q_ff[k] <= {q_ff[k-1][QW-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign rnd = {1'b0, q_ff[QW][QW-1:1]} + QW'(q_ff[QW][0]);
   assign limit = ctl_ff[QW].neg ? QW'(qjmc_pkg::SAT_NEG) : QW'(qjmc_pkg::SAT_POS);
   assign over = ctl_ff[QW].ovf || (rnd > limit);

   always_comb begin
      priority if (ctl_ff[QW].dzero) begin
         res_in.sat = ctl_ff[QW].nz;
         if (!ctl_ff[QW].nz) begin
            res_in.coef = '0;
         end else begin
            res_in.coef = ctl_ff[QW].neg ? qjmc_pkg::SAT_NEG : qjmc_pkg::SAT_POS;
         end
      end else if (over) begin
         res_in.sat = 1'b1;
         res_in.coef = ctl_ff[QW].neg ? qjmc_pkg::SAT_NEG : qjmc_pkg::SAT_POS;
      end else begin
         res_in.sat = 1'b0;
         res_in.coef = ctl_ff[QW].neg ? (32'd0 - rnd[31:0]) : rnd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign dout = res_ff;

endmodule

// ===== rtl/quintic_jerk_min_coeffs.sv =====
// pipeline depth: 11 front stages and 35 divider stages, then the output register
// throughput: one request per cycle while the skid entry is empty; the 33-step divider pipelines set the depth
// an output register plus one skid entry decouple the response side from the pipeline
// reset (synchronous, active high) clears the pipe, output and skid valid bits; payload keeps old data
// no clearing pass and no carried state between requests
module quintic_jerk_min_coeffs (
   input  logic        clock,
   input  logic        reset,
   qjmc_req_if.sink    req_chan,
   qjmc_rsp_if.source  rsp_chan
);

   localparam int unsigned LAT = qjmc_pkg::PIPE_LAT;
   localparam int unsigned XW = qjmc_pkg::XW;
   localparam int unsigned NUMW = qjmc_pkg::NUMW;
   localparam int unsigned MAGW = qjmc_pkg::MAGW;
   localparam int unsigned DUR_W = qjmc_pkg::DUR_W;

   // pipeline advance: the whole pipe moves unless the skid entry is occupied
   logic adv;

   logic [LAT-1:0]       valid_ff;
   qjmc_pkg::side_type   side_in;
   qjmc_pkg::side_type   side_ff [LAT];

   // stage 1: boundary differences
   logic signed [32:0]   dps_s1_ff, dvs_s1_ff, das_s1_ff;
   logic signed [32:0]   dps_s2_ff, dvs_s2_ff;
   logic signed [32:0]   dps_s3_ff, dvs_s3_ff;
   logic signed [31:0]   vs_s1_ff, as_s1_ff;
   logic [DUR_W-1:0]     d_ff [9];

   // first multiplier bank (stages 2-3)
   logic signed [55:0]   vs_d, as_d;
   logic signed [56:0]   das_d;
   logic signed [48:0]   dd;

   // stage 4: velocity residual and partial position residual
   logic signed [57:0]   r1_s4_ff;
   logic signed [73:0]   x0p_s4_ff, x0p_s5_ff, x0p_s6_ff;
   logic signed [55:0]   as_d_s4_ff;
   logic signed [56:0]   das_d_s4_ff;
   logic signed [48:0]   dd_s4_ff;

   // second multiplier bank (stages 5-6)
   logic signed [79:0]   as_dd;
   logic signed [81:0]   r1_d;
   logic signed [80:0]   das_dd;
   logic signed [72:0]   ddd;

   // stage 7: scaled residuals
   logic signed [XW-1:0] x0_ff, x1_ff, x2_ff;
   logic [qjmc_pkg::DEN3_W-1:0] d3_ff [5];

   // third and fourth multiplier banks: d^4 (stages 8-9), d^5 (stages 10-11)
   logic signed [96:0]   d4_full;
   logic signed [120:0]  d5_full;
   logic [qjmc_pkg::DEN4_W-1:0] d4_s10_ff, d4_s11_ff;

   // stages 8-11: numerators, sign and magnitude
   logic signed [NUMW-1:0] t20_ff, t15_ff, t12_ff, s3_ff, s4_ff, s5_ff;
   logic signed [NUMW-1:0] n3_ff, n4_ff, n5_ff;
   logic signed [NUMW-1:0] x0_e, x1_e, x2_e;
   qjmc_pkg::div_in_type  din3_in, din4_in, din5_in;
   qjmc_pkg::div_in_type  din3_s10_ff, din4_s10_ff, din5_s10_ff;
   qjmc_pkg::div_in_type  din3_s11_ff, din4_s11_ff, din5_s11_ff;

   qjmc_pkg::div_out_type dout3, dout4, dout5;

   // output register and skid entry
   qjmc_pkg::rsp_type inc;
   qjmc_pkg::rsp_type out_ff, skid_ff;
   logic              out_valid_ff, skid_valid_ff;
   logic              take;

   assign adv = !skid_valid_ff;
   assign req_chan.ready = adv;

   // sideband: start position and velocity pass through; acceleration is halved, half away from zero
   always_comb begin
      side_in.coef0 = req_chan.start_pos;
      side_in.coef1 = req_chan.start_vel;
      side_in.coef2 = {req_chan.start_acc[31], req_chan.start_acc[31:1]}
                    + 32'(req_chan.start_acc[0] & ~req_chan.start_acc[31]);
      side_in.dzero = (req_chan.duration == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (adv) begin
         dps_s1_ff <= 33'(req_chan.end_pos) - 33'(req_chan.start_pos);
         dvs_s1_ff <= 33'(req_chan.end_vel) - 33'(req_chan.start_vel);
         das_s1_ff <= 33'(req_chan.end_acc) - 33'(req_chan.start_acc);
         vs_s1_ff <= req_chan.start_vel;
         as_s1_ff <= req_chan.start_acc;
         d_ff[0] <= req_chan.duration;
         for (int k = 1; k < 9; k++) begin
            d_ff[k] <= d_ff[k-1];
         end
         dps_s2_ff <= dps_s1_ff;
         dvs_s2_ff <= dvs_s1_ff;
         dps_s3_ff <= dps_s2_ff;
         dvs_s3_ff <= dvs_s2_ff;
      end
   end

   // stages 2-3: vs*d, as*d, (ae-as)*d, d^2
   qjmc_mul #(.AW(32)) u_mul_vs (.clock(clock), .en(adv), .a(vs_s1_ff), .d(d_ff[0]),
                                 .p(vs_d));
   qjmc_mul #(.AW(32)) u_mul_as (.clock(clock), .en(adv), .a(as_s1_ff), .d(d_ff[0]),
                                 .p(as_d));
   qjmc_mul #(.AW(33)) u_mul_das (.clock(clock), .en(adv), .a(das_s1_ff), .d(d_ff[0]),
                                  .p(das_d));
   qjmc_mul #(.AW(25)) u_mul_dd (.clock(clock), .en(adv), .a($signed({1'b0, d_ff[0]})),
                                 .d(d_ff[0]), .p(dd));

   // stage 4: r1 = (ve-vs)<<16 - as*d, x0 partial = (pe-ps)<<33 - vs*d<<17
   always_ff @(posedge clock) begin
      if (adv) begin
         r1_s4_ff <= (58'(dvs_s3_ff) <<< 16) - 58'(as_d);
         x0p_s4_ff <= (74'(dps_s3_ff) <<< 33) - (74'(vs_d) <<< 17);
         as_d_s4_ff <= as_d;
         das_d_s4_ff <= das_d;
         dd_s4_ff <= dd;
         x0p_s5_ff <= x0p_s4_ff;
         x0p_s6_ff <= x0p_s5_ff;
      end
   end

   // stages 5-6
   qjmc_mul #(.AW(56)) u_mul_asd (.clock(clock), .en(adv), .a(as_d_s4_ff), .d(d_ff[3]),
                                  .p(as_dd));
   qjmc_mul #(.AW(58)) u_mul_r1 (.clock(clock), .en(adv), .a(r1_s4_ff), .d(d_ff[3]),
                                 .p(r1_d));
   qjmc_mul #(.AW(57)) u_mul_dasd (.clock(clock), .en(adv), .a(das_d_s4_ff), .d(d_ff[3]),
                                   .p(das_dd));
   qjmc_mul #(.AW(49)) u_mul_d3 (.clock(clock), .en(adv), .a(dd_s4_ff), .d(d_ff[3]),
                                 .p(ddd));

   // stage 7: residuals scaled by 2^49
   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff <= XW'(x0p_s6_ff) - XW'(as_dd);
         x1_ff <= XW'(r1_d) <<< 1;
         x2_ff <= XW'(das_dd) <<< 1;
         d3_ff[0] <= ddd[qjmc_pkg::DEN3_W-1:0];
         for (int k = 1; k < 5; k++) begin
            d3_ff[k] <= d3_ff[k-1];
         end
      end
   end

   // stages 8-11: d^4 then d^5
   qjmc_mul #(.AW(73)) u_mul_d4 (.clock(clock), .en(adv), .a($signed({1'b0, d3_ff[0]})),
                                 .d(d_ff[6]), .p(d4_full));
   qjmc_mul #(.AW(97)) u_mul_d5 (.clock(clock), .en(adv),
                                 .a($signed({1'b0, d4_full[qjmc_pkg::DEN4_W-1:0]})),
                                 .d(d_ff[8]), .p(d5_full));

   always_ff @(posedge clock) begin
      if (adv) begin
         d4_s10_ff <= d4_full[qjmc_pkg::DEN4_W-1:0];
         d4_s11_ff <= d4_s10_ff;
      end
   end

   assign x0_e = NUMW'(x0_ff);
   assign x1_e = NUMW'(x1_ff);
   assign x2_e = NUMW'(x2_ff);

   // stage 8: constant multiples of the residuals
   always_ff @(posedge clock) begin
      if (adv) begin
         t20_ff <= (x0_e <<< 4) + (x0_e <<< 2);
         t15_ff <= (x0_e <<< 4) - x0_e;
         t12_ff <= (x0_e <<< 3) + (x0_e <<< 2);
         s3_ff <= x2_e - (x1_e <<< 3);
         s4_ff <= (x1_e <<< 3) - x1_e - x2_e;
         s5_ff <= x2_e - (x1_e <<< 2) - (x1_e <<< 1);
      end
   end

   // stage 9: numerators of c3, c4, c5
   always_ff @(posedge clock) begin
      if (adv) begin
         n3_ff <= t20_ff + s3_ff;
         n4_ff <= s4_ff - t15_ff;
         n5_ff <= t12_ff + s5_ff;
      end
   end

   // stage 10: sign and magnitude for the unsigned dividers
   always_comb begin
      logic [NUMW-1:0] m3, m4, m5;
      m3 = n3_ff[NUMW-1] ? (NUMW'(0) - n3_ff) : n3_ff;
      m4 = n4_ff[NUMW-1] ? (NUMW'(0) - n4_ff) : n4_ff;
      m5 = n5_ff[NUMW-1] ? (NUMW'(0) - n5_ff) : n5_ff;
      din3_in.mag = m3[MAGW-1:0];
      din3_in.neg = n3_ff[NUMW-1];
      din3_in.dzero = side_ff[8].dzero;
      din4_in.mag = m4[MAGW-1:0];
      din4_in.neg = n4_ff[NUMW-1];
      din4_in.dzero = side_ff[8].dzero;
      din5_in.mag = m5[MAGW-1:0];
      din5_in.neg = n5_ff[NUMW-1];
      din5_in.dzero = side_ff[8].dzero;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         din3_s10_ff <= din3_in;
         din4_s10_ff <= din4_in;
         din5_s10_ff <= din5_in;
         din3_s11_ff <= din3_s10_ff;
         din4_s11_ff <= din4_s10_ff;
         din5_s11_ff <= din5_s10_ff;
      end
   end

   // stages 12-46: one divider pipeline per solved coefficient
   qjmc_div #(.DW(qjmc_pkg::DEN3_W), .SH(qjmc_pkg::SH3)) u_div3 (
      .clock(clock), .en(adv), .din(din3_s11_ff), .den(d3_ff[4]), .dout(dout3));
   qjmc_div #(.DW(qjmc_pkg::DEN4_W), .SH(qjmc_pkg::SH4)) u_div4 (
      .clock(clock), .en(adv), .din(din4_s11_ff), .den(d4_s11_ff), .dout(dout4));
   qjmc_div #(.DW(qjmc_pkg::DEN5_W), .SH(qjmc_pkg::SH5)) u_div5 (
      .clock(clock), .en(adv), .din(din5_s11_ff),
      .den(d5_full[qjmc_pkg::DEN5_W-1:0]), .dout(dout5));

   // result assembly at the end of the pipe
   always_comb begin
      inc.coef0 = side_ff[LAT-1].coef0;
      inc.coef1 = side_ff[LAT-1].coef1;
      inc.coef2 = side_ff[LAT-1].coef2;
      inc.coef3 = dout3.coef;
      inc.coef4 = dout4.coef;
      inc.coef5 = dout5.coef;
      inc.error_flag = side_ff[LAT-1].dzero | dout3.sat | dout4.sat | dout5.sat;
   end

   assign take = out_valid_ff & rsp_chan.ready;

   // output register with one skid entry; a full skid stalls the pipe combinationally
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (valid_ff[LAT-1]) begin
         if (!out_valid_ff || take) begin
            out_ff <= inc;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff <= inc;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.coef0 = out_ff.coef0;
   assign rsp_chan.coef1 = out_ff.coef1;
   assign rsp_chan.coef2 = out_ff.coef2;
   assign rsp_chan.coef3 = out_ff.coef3;
   assign rsp_chan.coef4 = out_ff.coef4;
   assign rsp_chan.coef5 = out_ff.coef5;
   assign rsp_chan.error_flag = out_ff.error_flag;

   // skid only fills behind a waiting output
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output valid");

   // a held skid entry is neither dropped nor overwritten
   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_chan.ready |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost while response stalled");

   // draining the skid refills the output on the same edge
   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      $fell(skid_valid_ff) |-> out_valid_ff && $past(rsp_chan.ready))
      else $error("skid drained without a response transfer");

endmodule
